// File: rtl/core/mbrtu_pkg.sv
// Package for the Modbus RTU slave frame handler core.
// Holds sizes, function codes, status and result codes for the frame handler core.
// No dependencies.
package mbrtu_pkg;
	localparam int REG_COUNT = 100;
	localparam int RX_DEPTH  = 256;
	localparam int RX_AW     = $clog2(RX_DEPTH);
	localparam int RX_CW     = RX_AW + 1;
	localparam int REG_AW    = 7;

	localparam logic [1:0] F_RX   = 2'd0;
	localparam logic [1:0] F_PULL = 2'd1;
	localparam logic [1:0] F_APPW = 2'd2;
	localparam logic [1:0] F_APPR = 2'd3;

	localparam logic [1:0] K_STAT = 2'd0;
	localparam logic [1:0] K_TX   = 2'd1;
	localparam logic [1:0] K_APP  = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ADDR  = 3'd1;
	localparam logic [2:0] ST_CRC   = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_SHORT = 3'd4;
	localparam logic [2:0] ST_NONE  = 3'd5;

	localparam logic [7:0] FC_READ = 8'h03;
	localparam logic [7:0] FC_WR1  = 8'h06;
	localparam logic [7:0] FC_WRN  = 8'h10;
	localparam logic [7:0] EXC_BIT = 8'h80;
	localparam logic [7:0] EXC_ILL = 8'h01;

	localparam logic [2:0] RK_NONE = 3'd0;
	localparam logic [2:0] RK_READ = 3'd1;
	localparam logic [2:0] RK_WR1  = 3'd2;
	localparam logic [2:0] RK_WRN  = 3'd3;
	localparam logic [2:0] RK_EXC  = 3'd4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction
endpackage

// File: rtl/core/mbrtu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mbrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/modbus_rtu_slave_frame_handler_core.sv
// Modbus RTU slave frame handler with holding-register banks.
// Depends on mbrtu_pkg and mbrtu_ram.
//
// A command is a transfer taken when start is high and busy is low. A received
// byte that does not end a frame and an application write are handled without
// leaving the idle state. An application read passes through S_APPR and a
// transmit pull through S_PULL and S_PULL2, as the memories have registered
// read data. The frame-end byte takes longer: S_CHK0 checks the length, then
// the CRC check walks the receive buffer one byte per cycle in S_CRC, S_HDR
// decodes the request and S_TAIL1 reports (S_CRC is skipped when the frame
// fails its length check, and the walk ends early when it fails its address
// check). A single-register write adds S_TAIL0, and a multi-register write
// walks the write bank in S_WRN. A result is flagged on the result ports by
// done, which is high for a single cycle, in the cycle in which busy falls;
// the receiver cannot stall it. The first REG_COUNT entries of the two register
// banks come out of reset as zero through a clearing pass in S_CLR during
// which busy is high. The device address register may be written through
// cfg_valid/cfg_ready whenever the core is idle.
module modbus_rtu_slave_frame_handler_core
	import mbrtu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,
	input  logic        rx_end,
	input  logic [6:0]  reg_index,
	input  logic [15:0] reg_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [1:0]  kind,
	output logic [2:0]  status,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	output logic [15:0] reg_data
);
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CHK0, S_CHK1, S_CRC, S_TAIL0, S_TAIL1, S_HDR,
		S_WRN, S_PULL, S_PULL2, S_APPR
	} state_t;

	state_t state_q;

	// Memory ports.
	logic             rx_we;
	logic [RX_AW-1:0] rx_wa, rx_ra;
	logic [7:0]       rx_wd, rx_rd;
	logic             rb_we, wb_we;
	logic [REG_AW-1:0] rb_wa, rb_ra, wb_wa, wb_ra;
	logic [15:0]      rb_wd, rb_rd, wb_wd, wb_rd;

	mbrtu_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx (
		.clk(clk), .we(rx_we), .waddr(rx_wa), .wdata(rx_wd), .raddr(rx_ra), .rdata(rx_rd));
	mbrtu_ram #(.WIDTH(16), .DEPTH(2 ** REG_AW)) u_rb (
		.clk(clk), .we(rb_we), .waddr(rb_wa), .wdata(rb_wd), .raddr(rb_ra), .rdata(rb_rd));
	mbrtu_ram #(.WIDTH(16), .DEPTH(2 ** REG_AW)) u_wb (
		.clk(clk), .we(wb_we), .waddr(wb_wa), .wdata(wb_wd), .raddr(wb_ra), .rdata(wb_rd));

	logic [7:0]        dev_q;
	logic [RX_CW-1:0]  cnt_q;      // bytes stored in the current frame
	logic              ovf_q;      // frame overflowed the buffer
	logic [RX_CW-1:0]  ptr_q;      // walk pointer over the buffer
	logic [15:0]       crc_q;      // running check CRC
	logic [7:0]        b1_q, crclo_q;
	logic [15:0]       start_q, qty_q;
	logic [6:0]        rstart_q, rqty_q;
	logic [2:0]        rkind_q;
	logic [7:0]        txpos_q;
	logic [15:0]       txcrc_q;
	logic [6:0]        widx_q;     // clear index and multi-write index
	logic [7:0]        hi_q;       // high byte held during multi-write
	logic              wph_q;      // multi-write byte phase
	logic              aok_q;      // application read index is in range

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// Response body length and static body bytes.
	logic [8:0] blen;
	always_comb begin
		case (rkind_q)
			RK_READ: blen = 9'd3 + {1'b0, rqty_q, 1'b0};
			RK_WR1, RK_WRN: blen = 9'd6;
			default: blen = 9'd3;
		endcase
	end

	logic [7:0] rdoff;      // position minus three
	logic [6:0] ridx;
	logic [7:0] ridx_w;
	assign rdoff  = txpos_q - 8'd3;
	assign ridx_w = {1'b0, rstart_q} + {1'b0, rdoff[7:1]};
	assign ridx   = ridx_w[6:0];

	// Byte selection for a pull, given registered bank data.
	logic [7:0] body;
	always_comb begin
		body = 8'h00;
		if (txpos_q == 8'd0) begin
			body = dev_q;
		end else begin
			case (rkind_q)
				RK_READ: begin
					if (txpos_q == 8'd1) body = FC_READ;
					else if (txpos_q == 8'd2) body = {rqty_q, 1'b0};
					else if (ridx_w >= 8'(REG_COUNT)) body = 8'h00;
					else body = rdoff[0] ? rb_rd[7:0] : rb_rd[15:8];
				end
				RK_WR1: begin
					if (txpos_q == 8'd1) body = FC_WR1;
					else if (txpos_q == 8'd3) body = {1'b0, rstart_q};
					else if (txpos_q == 8'd4) body = wb_rd[15:8];
					else if (txpos_q == 8'd5) body = wb_rd[7:0];
				end
				RK_WRN: begin
					if (txpos_q == 8'd1) body = FC_WRN;
					else if (txpos_q == 8'd3) body = {1'b0, rstart_q};
					else if (txpos_q == 8'd5) body = {1'b0, rqty_q};
				end
				default: begin
					if (txpos_q == 8'd1) body = {1'b0, rstart_q} | EXC_BIT;
					else body = EXC_ILL;
				end
			endcase
		end
	end

	logic [16:0] sum;
	assign sum = {1'b0, start_q} + {1'b0, qty_q};
	logic [9:0] need_wrn;
	assign need_wrn = 10'd9 + {qty_q[7:0], 1'b0};

	// Memory address and write control. The single write stores the value in
	// the request, a multi-register write stores the held high byte with the
	// low byte just read from the buffer.
	always_comb begin
		rx_we = 1'b0; rx_wa = cnt_q[RX_AW-1:0]; rx_wd = rx_byte;
		rx_ra = ptr_q[RX_AW-1:0];
		rb_we = 1'b0; rb_wa = reg_index; rb_wd = reg_value; rb_ra = ridx;
		wb_we = 1'b0; wb_wa = widx_q;    wb_wd = 16'h0000;  wb_ra = rstart_q;
		case (state_q)
			S_CLR: begin
				rb_we = 1'b1; rb_wa = widx_q; rb_wd = 16'h0000;
				wb_we = 1'b1;
			end
			S_IDLE: begin
				if (start && func == F_RX && !cnt_q[RX_AW] && !ovf_q) rx_we = 1'b1;
				if (start && func == F_APPW && reg_index < 7'(REG_COUNT)) rb_we = 1'b1;
				if (start && func == F_APPR) wb_ra = reg_index;
			end
			S_TAIL0: begin
				wb_we = 1'b1; wb_wd = qty_q;
			end
			S_WRN: begin
				if (!wph_q && ptr_q != RX_CW'(7)) begin
					wb_we = 1'b1; wb_wd = {hi_q, rx_rd};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			dev_q    <= 8'd1;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			ptr_q    <= '0;
			rkind_q  <= RK_NONE;
			rstart_q <= '0;
			rqty_q   <= '0;
			txpos_q  <= '0;
			txcrc_q  <= CRC_INIT;
			widx_q   <= '0;
			aok_q    <= 1'b0;
			done     <= 1'b0;
			kind     <= K_STAT;
			status   <= ST_OK;
			tx_byte  <= '0;
			tx_last  <= 1'b0;
			reg_data <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) dev_q <= cfg_data;
			case (state_q)
				S_CLR: begin
					widx_q <= widx_q + 7'd1;
					if (widx_q == 7'(REG_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						case (func)
							F_RX: begin
								if (cnt_q[RX_AW] || ovf_q) ovf_q <= 1'b1;
								else cnt_q <= cnt_q + 1'b1;
								if (rx_end) begin
									ptr_q <= '0;
									state_q <= S_CHK0;
								end
							end
							F_PULL: state_q <= S_PULL;
							F_APPW: ;
							default: begin
								aok_q <= (reg_index < 7'(REG_COUNT));
								state_q <= S_APPR;
							end
						endcase
					end
				end
				S_APPR: begin
					done <= 1'b1; kind <= K_APP; status <= ST_OK;
					tx_byte <= '0; tx_last <= 1'b0;
					reg_data <= aok_q ? wb_rd : 16'h0000;
					state_q <= S_IDLE;
				end
				S_CHK0: begin
					// Length and overflow, then start the CRC walk.
					crc_q <= CRC_INIT;
					if (ovf_q || cnt_q < RX_CW'(4)) begin
						status <= ST_SHORT; state_q <= S_TAIL1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						state_q <= S_CRC;
					end
				end
				S_CRC: begin
					// rx_rd holds byte ptr_q-1.
					if (ptr_q == RX_CW'(1)) begin
						if (rx_rd != dev_q) begin
							status <= ST_ADDR; state_q <= S_TAIL1;
						end
					end
					if (ptr_q == RX_CW'(2)) b1_q <= rx_rd;
					if (ptr_q == RX_CW'(3)) start_q[15:8] <= rx_rd;
					if (ptr_q == RX_CW'(4)) start_q[7:0] <= rx_rd;
					if (ptr_q == RX_CW'(5)) qty_q[15:8] <= rx_rd;
					if (ptr_q == RX_CW'(6)) qty_q[7:0] <= rx_rd;
					if (ptr_q == cnt_q - RX_CW'(1)) crclo_q <= rx_rd;
					if (ptr_q <= cnt_q - RX_CW'(2)) crc_q <= crc_byte(crc_q, rx_rd);
					if (ptr_q == cnt_q) begin
						state_q <= S_HDR;
						if ({rx_rd, crclo_q} != crc_q) begin
							status <= ST_CRC; state_q <= S_TAIL1;
						end
					end else if (!(ptr_q == RX_CW'(1) && rx_rd != dev_q)) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_HDR: begin
					state_q <= S_TAIL1;
					status <= ST_OK;
					if (b1_q != FC_READ && b1_q != FC_WR1 && b1_q != FC_WRN) begin
						rkind_q <= RK_EXC; rstart_q <= b1_q[6:0]; rqty_q <= '0;
						txpos_q <= '0; txcrc_q <= CRC_INIT;
					end else if (cnt_q < RX_CW'(8)) begin
						status <= ST_SHORT;
					end else if (b1_q == FC_WR1) begin
						if (start_q >= 16'(REG_COUNT)) status <= ST_RANGE;
						else begin
							widx_q <= start_q[6:0];
							rkind_q <= RK_WR1; rstart_q <= start_q[6:0]; rqty_q <= '0;
							txpos_q <= '0; txcrc_q <= CRC_INIT;
							state_q <= S_TAIL0;
						end
					end else if (sum >= 17'(REG_COUNT)) begin
						status <= ST_RANGE;
					end else if (b1_q == FC_READ) begin
						rkind_q <= RK_READ; rstart_q <= start_q[6:0]; rqty_q <= qty_q[6:0];
						txpos_q <= '0; txcrc_q <= CRC_INIT;
					end else if ({1'b0, cnt_q} < need_wrn) begin
						status <= ST_SHORT;
					end else begin
						widx_q <= start_q[6:0];
						ptr_q <= RX_CW'(7);
						wph_q <= 1'b0;
						start_q <= '0; // used as written-count
						rkind_q <= RK_WRN; rstart_q <= start_q[6:0]; rqty_q <= qty_q[6:0];
						txpos_q <= '0; txcrc_q <= CRC_INIT;
						state_q <= (qty_q == 16'd0) ? S_TAIL1 : S_WRN;
					end
				end
				S_TAIL0: state_q <= S_TAIL1; // the single write goes out in this cycle
				S_WRN: begin
					// Each register is read from the buffer as a high byte, then a low byte.
					wph_q <= ~wph_q;
					ptr_q <= ptr_q + 1'b1;
					if (wph_q) hi_q <= rx_rd;
					if (!wph_q && ptr_q != RX_CW'(7)) begin
						// rx_rd holds the low byte of the register written now.
						widx_q <= widx_q + 7'd1;
						start_q <= start_q + 16'd1;
						if (start_q + 16'd1 == qty_q) state_q <= S_TAIL1;
					end
				end
				S_TAIL1: begin
					done <= 1'b1; kind <= K_STAT;
					tx_byte <= '0; tx_last <= 1'b0; reg_data <= '0;
					cnt_q <= '0; ovf_q <= 1'b0;
					state_q <= S_IDLE;
				end
				S_PULL: state_q <= S_PULL2; // bank read in flight
				S_PULL2: begin
					done <= 1'b1; kind <= K_TX; reg_data <= '0;
					state_q <= S_IDLE;
					if (rkind_q == RK_NONE) begin
						status <= ST_NONE; tx_byte <= '0; tx_last <= 1'b0;
					end else begin
						status <= ST_OK; tx_last <= 1'b0;
						if ({1'b0, txpos_q} < blen) begin
							tx_byte <= body;
							txcrc_q <= crc_byte(txcrc_q, body);
							txpos_q <= txpos_q + 8'd1;
						end else if ({1'b0, txpos_q} == blen) begin
							tx_byte <= txcrc_q[7:0];
							txpos_q <= txpos_q + 8'd1;
						end else begin
							tx_byte <= txcrc_q[15:8]; tx_last <= 1'b1;
							rkind_q <= RK_NONE; rstart_q <= '0; rqty_q <= '0;
							txpos_q <= '0; txcrc_q <= CRC_INIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
